// ----- hw/rtl/char_class_bitmap_builder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Character class bitmap builder: assertion macros
// Concurrent assertion helpers shared by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef CHAR_CLASS_BITMAP_BUILDER_CORE_ASSERT_SVH
`define CHAR_CLASS_BITMAP_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define CCBB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define CCBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ccbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character class bitmap builder package
// Item types, parser codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package ccbb_pkg;

	localparam int unsigned BitmapBytes = 32;
	localparam int unsigned IdxW        = $clog2(BitmapBytes);

	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
	localparam logic [7:0] CHAR_UPPER_X   = 8'h58;

	typedef enum logic [0:0] {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_HEX_HI = 4'b0100,
		MODE_HEX_LO = 4'b1000
	} parse_mode_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]      set_byte;
		logic [IdxW-1:0] byte_index;
		logic            parse_error;
		logic            last;
	} out_item_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Decodes one ASCII hex digit in either case.
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.valid = 1'b0;
		d.value = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			d.valid = 1'b1;
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			d.valid = 1'b1;
			d.value = c[3:0] + 4'd9;
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/ccbb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream input channel
// Valid/ready channel that carries one stream item per transaction.
// ----------------------------------------------------------------------------
interface ccbb_in_if;
	import ccbb_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// ----- hw/rtl/ccbb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap output channel
// Valid/ready channel that carries one bitmap byte per transaction.
// ----------------------------------------------------------------------------
interface ccbb_out_if;
	import ccbb_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// ----- hw/rtl/char_class_bitmap_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character class bitmap builder core
// Parses an escaped character-set byte stream into a 256-bit membership map.
// ----------------------------------------------------------------------------
// A stream byte is accepted in every cycle while no readout is running: the
// escape parser and the bitmap update finish in the cycle the transaction is
// taken, so bytes go in back to back at one per clock. An end item starts a
// readout of 32 bitmap bytes through a single output register; the readout
// stalls while the sink is not ready. Input is held off until the last bitmap
// byte has been loaded into the output register, at which point the bitmap is
// cleared and new stream bytes are taken again even if that last byte still
// waits to be taken.
// ----------------------------------------------------------------------------
`include "char_class_bitmap_builder_core_assert.svh"

module char_class_bitmap_builder_core (
	input logic      clk,
	input logic      arst_n,
	ccbb_in_if.sink  stream,
	ccbb_out_if.source bitmap
);
	import ccbb_pkg::*;

	// Membership bitmap: entry i holds codes i*8 (bit 7) to i*8+7 (bit 0).
	logic [BitmapBytes-1:0][7:0] member_q;

	// Escape parser state.
	parse_mode_t mode_q;
	logic [3:0]  nibble_q;
	logic        error_q;

	// Readout sequencer and output register.
	logic            rd_active_q;
	logic [IdxW-1:0] rd_idx_q;
	logic            rd_err_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic            in_accept;
	logic            char_accept;
	logic            end_accept;
	logic            load;
	logic            rd_final;

	// Next parser state for an accepted stream byte.
	parse_mode_t     mode_d;
	logic [3:0]      nibble_d;
	logic            error_d;
	logic            mark;
	logic [7:0]      mark_code;
	hex_digit_t      hex;

	assign stream.ready = !rd_active_q;
	assign in_accept    = stream.valid && stream.ready;
	assign char_accept  = in_accept && (stream.item.opcode == OP_CHAR);
	assign end_accept   = in_accept && (stream.item.opcode == OP_END);

	// A bitmap byte moves into the output register whenever it is empty or is
	// being drained in this cycle.
	assign load     = rd_active_q && (!out_valid_q || bitmap.ready);
	assign rd_final = (rd_idx_q == IdxW'(BitmapBytes - 1));

	assign hex = hex_decode(stream.item.data_byte);

	// The parser walks one byte per transaction. After an error every byte is
	// ignored until the end item closes the set.
	always_comb begin
		mode_d    = mode_q;
		nibble_d  = nibble_q;
		error_d   = error_q;
		mark      = 1'b0;
		mark_code = stream.item.data_byte;
		if (!error_q) begin
			unique case (mode_q)
				MODE_NORMAL: begin
					if (stream.item.data_byte == CHAR_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						mark = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					if (stream.item.data_byte == CHAR_LOWER_X ||
						stream.item.data_byte == CHAR_UPPER_X) begin
						mode_d = MODE_HEX_HI;
					end else begin
						// Any other escaped byte stands for itself.
						mark   = 1'b1;
						mode_d = MODE_NORMAL;
					end
				end
				MODE_HEX_HI: begin
					if (hex.valid) begin
						nibble_d = hex.value;
						mode_d   = MODE_HEX_LO;
					end else begin
						error_d = 1'b1;
						mode_d  = MODE_NORMAL;
					end
				end
				MODE_HEX_LO: begin
					if (hex.valid) begin
						mark      = 1'b1;
						mark_code = {nibble_q, hex.value};
					end else begin
						error_d = 1'b1;
					end
					mode_d = MODE_NORMAL;
				end
				default: begin
					mode_d = MODE_NORMAL;
				end
			endcase
		end
	end

	// Parser registers. An end item latches the error flag for the readout
	// (an escape left open counts as an error) and restarts the parser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			nibble_q <= 4'd0;
			error_q  <= 1'b0;
			rd_err_q <= 1'b0;
		end else if (end_accept) begin
			rd_err_q <= error_q || (mode_q != MODE_NORMAL);
			mode_q   <= MODE_NORMAL;
			nibble_q <= 4'd0;
			error_q  <= 1'b0;
		end else if (char_accept) begin
			mode_q   <= mode_d;
			nibble_q <= nibble_d;
			error_q  <= error_d;
		end
	end

	// Bitmap: one bit set per accepted code, whole map cleared once the last
	// byte of a readout has been loaded. No byte is accepted during readout,
	// so the two never meet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
		end else if (load && rd_final) begin
			member_q <= '0;
		end else if (char_accept && mark) begin
			member_q[mark_code[7:3]] <= member_q[mark_code[7:3]] |
				(8'h80 >> mark_code[2:0]);
		end
	end

	// Readout sequencer: steps through the bitmap entries in ascending order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_active_q <= 1'b0;
			rd_idx_q    <= '0;
		end else if (end_accept) begin
			rd_active_q <= 1'b1;
			rd_idx_q    <= '0;
		end else if (load) begin
			if (rd_final) begin
				rd_active_q <= 1'b0;
			end
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// Output register; the valid flag drops only when a transaction completes
	// with nothing new to load behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (bitmap.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.set_byte    <= member_q[rd_idx_q];
			out_q.byte_index  <= rd_idx_q;
			out_q.parse_error <= rd_err_q;
			out_q.last        <= rd_final;
		end
	end

	assign bitmap.valid = out_valid_q;
	assign bitmap.item  = out_q;

	// An end item always starts a readout from the first bitmap byte.
	`CCBB_ASSERT_NEXT(a_end_starts_readout, end_accept, rd_active_q && (rd_idx_q == '0), "readout did not start at byte zero")
	// Loading the final byte leaves an empty bitmap and reopens the input.
	`CCBB_ASSERT_NEXT(a_final_clears_map, load && rd_final, (member_q == '0) && !rd_active_q, "bitmap not cleared after readout")
	// The parser never leaves normal mode while an error is pending.
	`CCBB_ASSERT_IMPL(a_error_parks_parser, error_q, mode_q == MODE_NORMAL, "parser active after error")

endmodule
